[sv/div64x32_pkg.sv]
`default_nettype none

package div64x32_pkg;

  // Field widths of the stream payload. These are fixed by the bus format.
  localparam int DIVIDEND_BITS = 64;
  localparam int DIVISOR_BITS  = 32;

  // Default operand widths used inside the divider.
  localparam int DEF_DIVIDEND_WIDTH = 64;
  localparam int DEF_DIVISOR_WIDTH  = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture operands from the input transaction
    logic prep;    // take magnitudes, record sign and zero-divisor flags
    logic step;    // one restoring shift-subtract step
    logic store;   // write the signed-corrected quotient to the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;    // the current step produces the final quotient bit
  } dp_stat_t;

endpackage

`default_nettype wire

[sv/divide_64_by_32.sv]
`default_nettype none

// Channel  Direction  tdata (low bit up)                     tuser
// s_*      in         dividend_bits[63:0], divisor_bits[95:64]  action (0 unsigned, 1 signed)
// m_*      out        quotient_bits[63:0]                    none
//
// Each transaction runs, from acceptance until the next input can be accepted, through an
// accept state, a state that takes operand magnitudes, DIVIDEND_WIDTH restoring
// shift-subtract steps (one quotient bit per cycle from the single subtractor), and a finish
// state that applies the sign and loads the output register. The output register lets
// a new input be accepted while a quotient waits on m_tready; a stalled output holds the
// divider in its finish state. Reset is synchronous, active high, and clears control state.

module divide_64_by_32
  import div64x32_pkg::*;
#(
  parameter int DIVIDEND_WIDTH = DEF_DIVIDEND_WIDTH,
  parameter int DIVISOR_WIDTH  = DEF_DIVISOR_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // Fields from bit 0 up: dividend_bits (64), divisor_bits (32).
  input  wire logic [DIVIDEND_BITS+DIVISOR_BITS-1:0] s_tdata,
  // Fields from bit 0 up: action (1).
  input  wire logic                                  s_tuser,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // Fields from bit 0 up: quotient_bits (64).
  output logic [DIVIDEND_BITS-1:0]                   m_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences one division at a time and owns both handshakes.
  div64x32_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the operands, the partial remainder and the quotient register.
  div64x32_dp #(
    .DIVIDEND_WIDTH (DIVIDEND_WIDTH),
    .DIVISOR_WIDTH  (DIVISOR_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (s_tuser),
    .dividend_bits (s_tdata[DIVIDEND_BITS-1:0]),
    .divisor_bits  (s_tdata[DIVIDEND_BITS+DIVISOR_BITS-1:DIVIDEND_BITS]),
    .quotient_bits (m_tdata)
  );

  // Once an input transaction is taken, the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a division was in progress");

  // A loaded operand pair is always followed by the magnitude step.
  a_prep_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.prep)
    else $error("operand load not followed by magnitude step");

  // With the output register empty, the quotient appears after the prep, divide and finish states.
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |-> ##(DIVIDEND_WIDTH + 3) m_tvalid)
    else $error("quotient did not appear after the expected latency");

endmodule

`default_nettype wire

[sv/div64x32_ctrl.sv]
`default_nettype none

module div64x32_ctrl
  import div64x32_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   m_tvalid_next;

  // The output register can take a new quotient when empty or being drained.
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (stat.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        cmd.store = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.store) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

`default_nettype wire

[sv/div64x32_dp.sv]
`default_nettype none

module div64x32_dp
  import div64x32_pkg::*;
#(
  parameter int DIVIDEND_WIDTH = DEF_DIVIDEND_WIDTH,
  parameter int DIVISOR_WIDTH  = DEF_DIVISOR_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dp_cmd_t                  cmd,
  output dp_stat_t                      stat,
  input  wire logic                     action,
  input  wire logic [DIVIDEND_BITS-1:0] dividend_bits,
  input  wire logic [DIVISOR_BITS-1:0]  divisor_bits,
  output logic [DIVIDEND_BITS-1:0]      quotient_bits
);

  localparam int DW    = DIVIDEND_WIDTH;
  localparam int VW    = DIVISOR_WIDTH;
  localparam int CNT_W = $clog2(DW);

  // The dividend register shifts left each step; quotient bits enter at the bottom,
  // so after DW steps it holds the unsigned quotient.
  logic [DW-1:0]    num;
  logic [VW-1:0]    den;
  logic [VW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             is_signed;
  logic             negate;
  logic             den_zero;
  logic [DW-1:0]    quot;

  logic [VW:0]      shifted;
  logic [VW+1:0]    diff;
  logic             borrow;
  logic             num_neg;
  logic             den_neg;
  logic [DW-1:0]    quot_fixed;

  assign shifted = {rem, num[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign borrow  = diff[VW+1];

  assign num_neg = is_signed && num[DW-1];
  assign den_neg = is_signed && den[VW-1];

  always_comb begin
    if (den_zero) begin
      quot_fixed = '0;
    end else if (negate) begin
      quot_fixed = -num;
    end else begin
      quot_fixed = num;
    end
  end

  assign stat.last     = (cnt == '0);
  assign quotient_bits = DIVIDEND_BITS'(quot);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num       <= dividend_bits[DW-1:0];
      den       <= divisor_bits[VW-1:0];
      is_signed <= action;
    end
    if (cmd.prep) begin
      if (num_neg) begin
        num <= -num;
      end
      if (den_neg) begin
        den <= -den;
      end
      negate   <= num_neg ^ den_neg;
      den_zero <= (den == '0);
      rem      <= '0;
    end
    if (cmd.step) begin
      if (borrow) begin
        rem <= shifted[VW-1:0];
        num <= {num[DW-2:0], 1'b0};
      end else begin
        rem <= diff[VW-1:0];
        num <= {num[DW-2:0], 1'b1};
      end
    end
    if (cmd.store) begin
      quot <= quot_fixed;
    end
  end

  // Step counter: control state, so it is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.prep) begin
      cnt <= CNT_W'(DW - 1);
    end else if (cmd.step) begin
      cnt <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire
